// ----- sv/hsps_pkg.sv -----
// Shared constants, types and the half-step phase table for the stepper unit.
package hsps_pkg;

  // Width of the internal position counter
  localparam int unsigned POSITION_BITS = 24;
  // Width of the target and reported position fields
  localparam int unsigned TARGET_W      = 24;
  localparam int unsigned INTERVAL_W    = 20;
  localparam int unsigned COIL_W        = 4;
  localparam int unsigned PHASE_W       = 3;
  // Compare width holds both counter and target, sign-extended
  localparam int unsigned CMP_W =
    ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) + 1;

  localparam logic [INTERVAL_W-1:0] ELAPSED_MAX    = '1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1465);

  localparam logic signed [POSITION_BITS-1:0] POS_MAX =
    {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_MIN =
    {1'b1, {(POSITION_BITS-1){1'b0}}};

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic [COIL_W-1:0]          coils;
    logic signed [TARGET_W-1:0] position;
    logic                       ready_res;
  } result_t;

  // Half-step coil pattern for each phase, coils DCBA
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      3'd0:    pat = 4'b0001;
      3'd1:    pat = 4'b0011;
      3'd2:    pat = 4'b0010;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0100;
      3'd5:    pat = 4'b1100;
      3'd6:    pat = 4'b1000;
      3'd7:    pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

// ----- sv/hsps_if.sv -----
// Valid/ready channel interfaces for tick requests and step results.
interface hsps_req_if;
  logic                                          valid;
  logic                                          ready;
  logic                                          op;
  logic signed [hsps_pkg::TARGET_W-1:0]          target_position;

  modport source (output valid, output op, output target_position, input ready);
  modport sink   (input valid, input op, input target_position, output ready);
endinterface

interface hsps_res_if;
  logic                                          valid;
  logic                                          ready;
  logic [hsps_pkg::COIL_W-1:0]                   coils;
  logic signed [hsps_pkg::TARGET_W-1:0]          position;
  logic                                          ready_res;

  modport source (output valid, output coils, output position, output ready_res,
                  input ready);
  modport sink   (input valid, input coils, input position, input ready_res,
                  output ready);
endinterface

// ----- sv/hsps_core.sv -----
// Position, phase and elapsed-tick state with the per-tick step decision.
module hsps_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 tick_i,
  input  hsps_pkg::op_e                        op_i,
  input  logic signed [hsps_pkg::TARGET_W-1:0] target_i,
  input  logic [hsps_pkg::INTERVAL_W-1:0]      interval_i,
  output hsps_pkg::result_t                    res_o
);

  logic signed [hsps_pkg::POSITION_BITS-1:0] step_count_q, step_count_d;
  logic [hsps_pkg::PHASE_W-1:0]              phase_q, phase_d;
  logic [hsps_pkg::INTERVAL_W-1:0]           elapsed_q, elapsed_d, elapsed_inc;
  logic [hsps_pkg::COIL_W-1:0]               coil_q, coil_d;

  logic signed [hsps_pkg::CMP_W-1:0] cnt_ext, tgt_ext, cnt_next_ext;
  logic                              step_up, step_dn, due;

  assign cnt_ext = hsps_pkg::CMP_W'(step_count_q);
  assign tgt_ext = hsps_pkg::CMP_W'(target_i);

  // Saturating tick count, then the step decision
  assign elapsed_inc = (elapsed_q == hsps_pkg::ELAPSED_MAX) ? elapsed_q
                                                            : elapsed_q + 1'b1;
  assign due     = (op_i == hsps_pkg::OP_TICK) && (elapsed_inc > interval_i);
  assign step_up = due && (cnt_ext < tgt_ext) && (step_count_q != hsps_pkg::POS_MAX);
  assign step_dn = due && (cnt_ext > tgt_ext) && (step_count_q != hsps_pkg::POS_MIN);

  // Next state for one tick
  always_comb begin
    step_count_d = step_count_q;
    phase_d      = phase_q;
    coil_d       = coil_q;
    elapsed_d    = elapsed_inc;
    if (op_i == hsps_pkg::OP_CLEAR) begin
      step_count_d = '0;
    end else if (step_up) begin
      step_count_d = step_count_q + 1'b1;
      phase_d      = phase_q + 1'b1;
      coil_d       = hsps_pkg::coil_pattern(phase_q + 1'b1);
      elapsed_d    = '0;
    end else if (step_dn) begin
      step_count_d = step_count_q - 1'b1;
      phase_d      = phase_q - 1'b1;
      coil_d       = hsps_pkg::coil_pattern(phase_q - 1'b1);
      elapsed_d    = '0;
    end
  end

  // Result of this tick, taken from the next state
  assign cnt_next_ext    = hsps_pkg::CMP_W'(step_count_d);
  assign res_o.coils     = coil_d;
  assign res_o.position  = cnt_next_ext[hsps_pkg::TARGET_W-1:0];
  assign res_o.ready_res = (cnt_next_ext == tgt_ext);

  // State advances only on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= '0;
      phase_q      <= '0;
      elapsed_q    <= '0;
      coil_q       <= '0;
    end else if (tick_i) begin
      step_count_q <= step_count_d;
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      coil_q       <= coil_d;
    end
  end

endmodule

// ----- sv/half_step_position_stepper_unit.sv -----
// Half-step stepper position unit: one tick transaction in, one result out.
// An accepted tick's result is registered and offered in the cycle after.
// Throughput: one tick per clock; the single result register refills in the
// cycle it is taken, so input ready drops only while a result waits unclaimed.
// Reset clears position, phase, elapsed count, coils and the result valid;
// the step interval returns to 1465 ticks.
module half_step_position_stepper_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hsps_pkg::INTERVAL_W-1:0]     cfg_wdata_i,
  hsps_req_if.sink                            req_i,
  hsps_res_if.source                          res_o
);

  logic [hsps_pkg::INTERVAL_W-1:0] interval_q;
  logic                            res_valid_q;
  hsps_pkg::result_t               res_q, res_d;
  logic                            accept;

  // Step interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= hsps_pkg::INTERVAL_RESET;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  hsps_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (accept),
    .op_i       (hsps_pkg::op_e'(req_i.op)),
    .target_i   (req_i.target_position),
    .interval_i (interval_q),
    .res_o      (res_d)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.coils     = res_q.coils;
  assign res_o.position  = res_q.position;
  assign res_o.ready_res = res_q.ready_res;

endmodule

// ----- sv/hsps_checker.sv -----
// Port-level checks for the stepper unit, bound onto the top level.
module hsps_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 in_op_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [hsps_pkg::COIL_W-1:0]          out_coils_i,
  input logic signed [hsps_pkg::TARGET_W-1:0] out_position_i,
  input logic                                 out_ready_res_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_coils_i) && $stable(out_position_i) && $stable(out_ready_res_i))
    else $error("result payload changed while stalled");

  // Every accepted tick yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted tick produced no result");

  // A clear transaction reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == hsps_pkg::OP_CLEAR) |=>
      out_position_i == '0)
    else $error("clear did not zero the position");

  // Half-step patterns drive at most two coils
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones(out_coils_i) <= 2)
    else $error("more than two coils driven");

endmodule

bind half_step_position_stepper_unit hsps_checker u_hsps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .in_op_i         (req_i.op),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .out_coils_i     (res_o.coils),
  .out_position_i  (res_o.position),
  .out_ready_res_i (res_o.ready_res)
);

// ----- test/hsps_position_checker.sv -----
// Result checker for the half-step stepper unit: predicts every tick and compares results.
`timescale 1ns / 100ps
module hsps_position_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hsps_pkg::INTERVAL_W-1:0] cfg_wdata_i,
  hsps_req_if                             req_i,
  hsps_res_if                             res_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o
);

  // Counter limits of the internal position register
  localparam longint POS_TOP    = (longint'(1) <<< (hsps_pkg::POSITION_BITS - 1)) - 1;
  localparam longint POS_BOTTOM = -POS_TOP - 1;
  // Half-step coil sequence, phase 0 in the low nibble
  localparam logic [8*hsps_pkg::COIL_W-1:0] COIL_SEQ =
    {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

  // Predicted motor state
  logic [hsps_pkg::INTERVAL_W-1:0] interval_cfg;
  logic [hsps_pkg::INTERVAL_W-1:0] ticks_since_step;
  longint                          shaft_pos;
  logic [hsps_pkg::PHASE_W-1:0]    seq_phase;
  logic [hsps_pkg::COIL_W-1:0]     coil_drive;
  hsps_pkg::result_t               expected_results[$];
  hsps_pkg::result_t               observed;

  // Advance the motor model by one tick and return the result it produces
  function automatic hsps_pkg::result_t predict_tick(
    input hsps_pkg::op_e                        tick_op,
    input logic signed [hsps_pkg::TARGET_W-1:0] goal
  );
    longint            goal_l;
    hsps_pkg::result_t r;
    goal_l = longint'(goal);
    if (ticks_since_step != hsps_pkg::ELAPSED_MAX) ticks_since_step++;
    if (tick_op == hsps_pkg::OP_CLEAR) begin
      shaft_pos = 0;
    end else if (ticks_since_step > interval_cfg) begin
      if (shaft_pos < goal_l && shaft_pos < POS_TOP) begin
        shaft_pos++;
        ticks_since_step = '0;
        seq_phase = seq_phase + 1'b1;
        coil_drive = COIL_SEQ[{seq_phase, 2'b00} +: hsps_pkg::COIL_W];
      end else if (shaft_pos > goal_l && shaft_pos > POS_BOTTOM) begin
        shaft_pos--;
        ticks_since_step = '0;
        seq_phase = seq_phase - 1'b1;
        coil_drive = COIL_SEQ[{seq_phase, 2'b00} +: hsps_pkg::COIL_W];
      end
    end
    r.coils     = coil_drive;
    r.position  = shaft_pos[hsps_pkg::TARGET_W-1:0];
    r.ready_res = (shaft_pos == goal_l);
    return r;
  endfunction

  // Compare one result transaction with the oldest prediction
  task automatic compare_result(input hsps_pkg::result_t got);
    hsps_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got coils=%h position=%0d ready=%b",
               $time, got.coils, $signed(got.position), got.ready_res);
      mismatches_o++;
      return;
    end
    want = expected_results.pop_front();
    if (got.coils !== want.coils) begin
      $display("%0t: coils expected %h, got %h", $time, want.coils, got.coils);
      mismatches_o++;
    end
    if (got.position !== want.position) begin
      $display("%0t: position expected %0d, got %0d", $time,
               $signed(want.position), $signed(got.position));
      mismatches_o++;
    end
    if (got.ready_res !== want.ready_res) begin
      $display("%0t: ready expected %b, got %b", $time, want.ready_res, got.ready_res);
      mismatches_o++;
    end
  endtask

  // Watch config writes and both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_cfg     = hsps_pkg::INTERVAL_RESET;
      ticks_since_step = '0;
      shaft_pos        = 0;
      seq_phase        = '0;
      coil_drive       = '0;
      mismatches_o     = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) interval_cfg = cfg_wdata_i;
      // pop before push: a result never belongs to a tick taken at the same edge
      if (res_i.valid && res_i.ready) begin
        observed.coils     = res_i.coils;
        observed.position  = res_i.position;
        observed.ready_res = res_i.ready_res;
        compare_result(observed);
      end
      if (req_i.valid && req_i.ready)
        expected_results.push_back(predict_tick(hsps_pkg::op_e'(req_i.op),
                                                req_i.target_position));
      pending_o <= expected_results.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the stepper unit testbench: clock, reset, tick stimulus and the verdict.
`timescale 1ns / 100ps
module testbench;

  // Ticks sent in each phase of the random part
  localparam int unsigned PHASE_ITEMS = 160;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [hsps_pkg::INTERVAL_W-1:0] cfg_wdata_i = '0;
  int unsigned                     mismatches;
  int unsigned                     pending;
  int unsigned                     send_idle_pct  = 0;
  int unsigned                     sink_stall_pct = 0;

  hsps_req_if req_if();
  hsps_res_if res_if();

  always #1 clk_i = ~clk_i;

  half_step_position_stepper_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  hsps_position_checker u_position_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_if),
    .res_i        (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Result side: random back-pressure at the current stall rate
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offer one tick, with a random gap first; valid stays high after acceptance
  task automatic send_tick(input hsps_pkg::op_e op,
                           input logic signed [hsps_pkg::TARGET_W-1:0] goal);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.op              <= op;
    req_if.target_position <= goal;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Single-cycle write of the step interval; only called while idle
  task automatic write_interval(input logic [hsps_pkg::INTERVAL_W-1:0] ticks);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic signed [hsps_pkg::TARGET_W-1:0] goal;
    int unsigned                          pick;
    req_if.valid           <= 1'b0;
    req_if.op              <= hsps_pkg::OP_TICK;
    req_if.target_position <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset interval: too few ticks for a step, coils stay off
    send_tick(hsps_pkg::OP_TICK, 24'sd5);
    send_tick(hsps_pkg::OP_TICK, '0);
    send_tick(hsps_pkg::OP_CLEAR, '0);
    drain_results();

    // zero interval: one step per tick, up then down through the phase wrap
    write_interval('0);
    repeat (4) send_tick(hsps_pkg::OP_TICK, 24'sd3);
    repeat (6) send_tick(hsps_pkg::OP_TICK, -24'sd2);
    send_tick(hsps_pkg::OP_CLEAR, 24'sd7);
    send_tick(hsps_pkg::OP_CLEAR, '0);
    send_tick(hsps_pkg::OP_TICK, hsps_pkg::POS_MAX);
    send_tick(hsps_pkg::OP_TICK, hsps_pkg::POS_MIN);
    send_tick(hsps_pkg::OP_TICK, '0);
    drain_results();

    // interval of one: a step every second tick
    write_interval(hsps_pkg::INTERVAL_W'(1));
    repeat (4) send_tick(hsps_pkg::OP_TICK, -24'sd1);
    drain_results();

    // maximum interval: the motor never moves
    write_interval(hsps_pkg::ELAPSED_MAX);
    repeat (3) send_tick(hsps_pkg::OP_TICK, 24'sd100);

    // random part: hold a nearby goal for a while, with clears and far targets mixed in
    goal = '0;
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin
          send_idle_pct = 0;  sink_stall_pct = 0;
          write_interval('0);
        end
        1: begin
          send_idle_pct = 57; sink_stall_pct = 0;
          write_interval(hsps_pkg::INTERVAL_W'(2));
        end
        2: begin
          send_idle_pct = 0;  sink_stall_pct = 57;
          write_interval(hsps_pkg::INTERVAL_W'(1));
        end
        default: begin
          send_idle_pct = 34; sink_stall_pct = 34;
          write_interval(hsps_pkg::INTERVAL_W'($urandom_range(5)));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off until the pipeline is empty
        if (n == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(99);
        if (pick < 12)
          goal = hsps_pkg::TARGET_W'($urandom_range(40)) - hsps_pkg::TARGET_W'(20);
        if (pick < 4)
          send_tick(hsps_pkg::OP_CLEAR, (pick < 2) ? '0 : goal);
        else if (pick < 9)
          send_tick(hsps_pkg::OP_TICK, hsps_pkg::TARGET_W'($urandom()));
        else
          send_tick(hsps_pkg::OP_TICK, goal);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hsps_pkg.sv
sv/hsps_if.sv
sv/hsps_core.sv
sv/half_step_position_stepper_unit.sv
sv/hsps_checker.sv
test/hsps_position_checker.sv
test/testbench.sv
